// ===== hw/rtl/ces_pkg.sv =====
// Shared types and constants for the console escape stripper.
`timescale 1ns / 1ps
`default_nettype none
package ces_pkg;

    localparam int MAX_PARAMS_DEF = 16;
    localparam int QDEPTH         = 4;
    localparam int QAW            = $clog2(QDEPTH);

    // one expanded word group: up to four characters for a single input byte
    typedef struct packed {
        logic [3:0][7:0] chars;
        logic [1:0]      last_idx;
        logic            nl;
    } t_rec;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage
`default_nettype wire

// ===== hw/rtl/ces_if.sv =====
// Valid/ready channel interfaces for the input byte and output character words.
`timescale 1ns / 1ps
`default_nettype none
interface ces_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink   (input valid, input in_byte, output ready);
endinterface

interface ces_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_char;
    logic       last_of_run;
    logic       line_ended;

    modport source (output valid, output out_char, output last_of_run,
                    output line_ended, input ready);
    modport sink   (input valid, input out_char, input last_of_run,
                    input line_ended, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/ces_front.sv =====
// Front end: escape sequence parser that classifies each byte into a character group.
`timescale 1ns / 1ps
`default_nettype none
module ces_front #(
    parameter int MAX_PARAMS = ces_pkg::MAX_PARAMS_DEF
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    ces_in_if.sink              i_in,
    input  wire ces_pkg::t_q_stat i_q_stat,
    output logic                o_push,
    output ces_pkg::t_rec       o_rec
);
    import ces_pkg::*;

    localparam int PW = ($clog2(MAX_PARAMS) > 3) ? $clog2(MAX_PARAMS) : 3;
    localparam logic [PW-1:0] P_LIM    = PW'(MAX_PARAMS - 1);
    localparam logic [PW-1:0] PAL_DIGS = PW'(7);

    typedef enum logic [3:0] {
        M_NORMAL  = 4'd0,
        M_ESC     = 4'd1,
        M_SQUARE  = 4'd2,
        M_GETPARS = 4'd3,
        M_GOTPARS = 4'd4,
        M_FUNCKEY = 4'd5,
        M_HASH    = 4'd6,
        M_SETG0   = 4'd7,
        M_SETG1   = 4'd8,
        M_PERCENT = 4'd9,
        M_NONSTD  = 4'd11,
        M_PALETTE = 4'd12
    } t_mode;

    t_mode         r_mode, n_mode;
    logic [PW-1:0] r_pcnt, n_pcnt;
    logic          r_nl, n_nl;
    logic [2:0]    cnt;
    logic [3:0][7:0] chars;
    logic [7:0]    c;
    logic [PW-1:0] base;
    logic          accept;
    logic          is_hex;
    logic          is_digit;

    assign c        = i_in.in_byte;
    assign i_in.ready = !i_q_stat.full;
    assign accept   = i_in.valid && !i_q_stat.full;
    assign is_digit = (c >= 8'h30) && (c <= 8'h39);
    assign is_hex   = is_digit || ((c >= 8'h41) && (c <= 8'h46)) ||
                      ((c >= 8'h61) && (c <= 8'h66));

    always_comb begin
        n_mode = r_mode;
        n_pcnt = r_pcnt;
        n_nl   = r_nl;
        cnt    = 3'd0;
        chars  = '0;
        base   = r_pcnt;
        unique case (r_mode)
            M_ESC: begin
                n_mode = M_NORMAL;
                if (c == 8'h5B) n_mode = M_SQUARE;
                else if (c == 8'h5D) n_mode = M_NONSTD;
                else if (c == 8'h25) n_mode = M_PERCENT;
                else if (c == 8'h28) n_mode = M_SETG0;
                else if (c == 8'h29) n_mode = M_SETG1;
                else if (c == 8'h23) n_mode = M_HASH;
                else if (c == 8'h45 || c == 8'h44) begin
                    n_nl     = 1'b1;
                    chars[0] = 8'd10;
                    cnt      = 3'd1;
                end
            end
            M_NONSTD: begin
                if (c == 8'h50) begin
                    n_pcnt = '0;
                    n_mode = M_PALETTE;
                end else begin
                    n_mode = M_NORMAL;
                end
            end
            M_PALETTE: begin
                if (is_hex) begin
                    n_pcnt = r_pcnt + 1'b1;
                    if (n_pcnt >= PAL_DIGS) n_mode = M_NORMAL;
                end else begin
                    n_mode = M_NORMAL;
                end
            end
            M_SQUARE, M_GETPARS: begin
                if (r_mode == M_SQUARE) begin
                    base   = '0;
                    n_pcnt = '0;
                end
                if (r_mode == M_SQUARE && c == 8'h5B) begin
                    n_mode = M_FUNCKEY;
                end else if (r_mode == M_SQUARE && c == 8'h3F) begin
                    n_mode = M_GETPARS;
                end else if (c == 8'h3B && base < P_LIM) begin
                    n_pcnt = base + 1'b1;
                    n_mode = M_GETPARS;
                end else if (is_digit) begin
                    n_mode = M_GETPARS;
                end else begin
                    n_mode = M_NORMAL;
                end
            end
            M_GOTPARS, M_FUNCKEY, M_HASH, M_SETG0, M_SETG1, M_PERCENT: begin
                n_mode = M_NORMAL;
            end
            default: begin
                n_mode = M_NORMAL;
                priority if (c == 8'd10) begin
                    n_nl     = 1'b1;
                    chars[0] = 8'd10;
                    cnt      = 3'd1;
                end else if (c == 8'd13 || c == 8'd14 || c == 8'd15 ||
                             c == 8'd24 || c == 8'd26) begin
                    cnt = 3'd0;
                end else if (c == 8'd27) begin
                    n_mode = M_ESC;
                end else if (c == 8'd155) begin
                    n_mode = M_SQUARE;
                end else begin
                    n_nl = 1'b0;
                    priority if (c == 8'd9 || (c >= 8'd32 && c <= 8'd126) ||
                                 c >= 8'd160) begin
                        chars[0] = c;
                        cnt      = 3'd1;
                    end else if (c == 8'd127) begin
                        chars[0] = 8'h5E;
                        chars[1] = 8'h3F;
                        cnt      = 3'd2;
                    end else if (c >= 8'd128) begin
                        chars[0] = 8'h5C;
                        chars[1] = 8'h30 + {6'b0, c[7:6]};
                        chars[2] = 8'h30 + {5'b0, c[5:3]};
                        chars[3] = 8'h30 + {5'b0, c[2:0]};
                        cnt      = 3'd4;
                    end else if (c == 8'd11 || c == 8'd12) begin
                        chars[0] = 8'h30;
                        chars[1] = 8'h78;
                        chars[2] = (c == 8'd11) ? 8'h42 : 8'h43;
                        cnt      = 3'd3;
                    end else begin
                        chars[0] = 8'h5E;
                        chars[1] = c + 8'd64;
                        cnt      = 3'd2;
                    end
                end
            end
        endcase
    end

    assign o_push         = accept && (cnt != 3'd0);
    assign o_rec.chars    = chars;
    assign o_rec.last_idx = 2'(cnt - 3'd1);
    assign o_rec.nl       = n_nl;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= M_NORMAL;
            r_pcnt <= '0;
            r_nl   <= 1'b0;
        end else if (accept) begin
            r_mode <= n_mode;
            r_pcnt <= n_pcnt;
            r_nl   <= n_nl;
        end
    end

endmodule
`default_nettype wire

// ===== hw/rtl/ces_queue.sv =====
// Short queue of character groups between the parser and the output serializer.
`timescale 1ns / 1ps
`default_nettype none
module ces_queue (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire ces_pkg::t_rec    i_rec,
    input  wire logic             i_pop,
    output ces_pkg::t_rec         o_head,
    output ces_pkg::t_q_stat      o_stat
);
    import ces_pkg::*;

    t_rec           r_slot [QDEPTH];
    logic [QAW-1:0] r_wr, r_rd;
    logic [QAW:0]   r_cnt;
    logic           do_push, do_pop;

    assign o_stat.full  = (r_cnt == (QAW+1)'(QDEPTH));
    assign o_stat.empty = (r_cnt == '0);
    assign do_push      = i_push && !o_stat.full;
    assign do_pop       = i_pop && !o_stat.empty;
    assign o_head       = r_slot[r_rd];

    always_ff @(posedge i_clk) begin
        if (do_push) r_slot[r_wr] <= i_rec;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) r_wr <= r_wr + 1'b1;
            if (do_pop)  r_rd <= r_rd + 1'b1;
            r_cnt <= r_cnt + (QAW+1)'(do_push) - (QAW+1)'(do_pop);
        end
    end

endmodule
`default_nettype wire

// ===== hw/rtl/ces_back.sv =====
// Back end: serializes queued character groups into one output word per cycle while the receiver is ready.
`timescale 1ns / 1ps
`default_nettype none
module ces_back (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire ces_pkg::t_rec    i_head,
    input  wire ces_pkg::t_q_stat i_q_stat,
    output logic                  o_pop,
    ces_out_if.source             o_out
);
    import ces_pkg::*;

    logic       r_valid;
    logic [7:0] r_char;
    logic       r_last;
    logic       r_nl;
    logic [1:0] r_idx;
    logic       load;
    logic       at_last;

    assign load    = (!r_valid || o_out.ready) && !i_q_stat.empty;
    assign at_last = (r_idx == i_head.last_idx);
    assign o_pop   = load && at_last;

    assign o_out.valid       = r_valid;
    assign o_out.out_char    = r_char;
    assign o_out.last_of_run = r_last;
    assign o_out.line_ended  = r_nl;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else begin
            if (!r_valid || o_out.ready) r_valid <= !i_q_stat.empty;
            if (load) r_idx <= at_last ? 2'd0 : r_idx + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_char <= i_head.chars[r_idx];
            r_last <= at_last;
            r_nl   <= i_head.nl;
        end
    end

endmodule
`default_nettype wire

// ===== hw/rtl/console_escape_stripper.sv =====
// Top level: console escape sequence stripper producing printable log text.
// The first character of a byte passes through the group queue and then the output register.
// The serializer sends one output word per cycle while the receiver is ready; a byte yields
// 1 to 4 characters or none, and the parser takes new bytes while the group queue is not full.
// A four-entry group queue separates the parser from the serializer.
// Reset (synchronous, active low) returns the parser to normal text and empties the queue.
`timescale 1ns / 1ps
`default_nettype none
module console_escape_stripper #(
    parameter int MAX_PARAMS = ces_pkg::MAX_PARAMS_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    ces_in_if.sink    i_in,
    ces_out_if.source o_out
);
    import ces_pkg::*;

    logic    push;
    logic    pop;
    t_rec    rec;
    t_rec    head;
    t_q_stat q_stat;

    ces_front #(
        .MAX_PARAMS (MAX_PARAMS)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (i_in),
        .i_q_stat (q_stat),
        .o_push   (push),
        .o_rec    (rec)
    );

    ces_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_rec   (rec),
        .i_pop   (pop),
        .o_head  (head),
        .o_stat  (q_stat)
    );

    ces_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_head   (head),
        .i_q_stat (q_stat),
        .o_pop    (pop),
        .o_out    (o_out)
    );

endmodule
`default_nettype wire

// ===== sim/tb.sv =====
// Testbench for console_escape_stripper: directed and random byte streams checked per character.
`timescale 1ns / 1ps
module tb;
    import ces_pkg::*;

    localparam logic [3:0] PM_TEXT    = 4'd0;
    localparam logic [3:0] PM_ESC     = 4'd1;
    localparam logic [3:0] PM_SQUARE  = 4'd2;
    localparam logic [3:0] PM_GETPARS = 4'd3;
    localparam logic [3:0] PM_GOTPARS = 4'd4;
    localparam logic [3:0] PM_FUNCKEY = 4'd5;
    localparam logic [3:0] PM_HASH    = 4'd6;
    localparam logic [3:0] PM_SETG0   = 4'd7;
    localparam logic [3:0] PM_SETG1   = 4'd8;
    localparam logic [3:0] PM_PERCENT = 4'd9;
    localparam logic [3:0] PM_NONSTD  = 4'd11;
    localparam logic [3:0] PM_PALETTE = 4'd12;

    localparam logic [7:0] TAB = 8'h09;
    localparam logic [7:0] LF  = 8'h0A;
    localparam logic [7:0] VT  = 8'h0B;
    localparam logic [7:0] FF  = 8'h0C;
    localparam logic [7:0] CR  = 8'h0D;
    localparam logic [7:0] SO  = 8'h0E;
    localparam logic [7:0] SI  = 8'h0F;
    localparam logic [7:0] CAN = 8'h18;
    localparam logic [7:0] SUB = 8'h1A;
    localparam logic [7:0] ESC = 8'h1B;
    localparam logic [7:0] DEL = 8'h7F;
    localparam logic [7:0] CSI = 8'h9B;

    localparam int LATENCY_WAIT = 8;
    localparam int STALL_LIMIT  = 2000;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
        logic       nl;
    } char_word_t;

    logic i_clk = 1'b0;
    logic i_rst_n;

    ces_in_if  in_if ();
    ces_out_if out_if ();

    console_escape_stripper dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_if),
        .o_out  (out_if)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // predictor state
    logic [3:0] parse_st    = PM_TEXT;
    logic [3:0] sep_cnt     = 4'd0;
    logic       at_line_end = 1'b0;

    char_word_t exp_chars[$];

    int errors      = 0;
    int n_in        = 0;
    int n_out       = 0;
    int n_seq       = 0;
    int send_idle   = 0;
    int recv_stall  = 0;
    int quiet_count = 0;

    function automatic bit is_hex(input logic [7:0] c);
        return (c >= "0" && c <= "9") || (c >= "A" && c <= "F") || (c >= "a" && c <= "f");
    endfunction

    function automatic void bracket_step(input logic [7:0] c);
        if (c == ";" && sep_cnt < MAX_PARAMS_DEF - 1) begin
            sep_cnt  = sep_cnt + 4'd1;
            parse_st = PM_GETPARS;
        end else if (c >= "0" && c <= "9") begin
            parse_st = PM_GETPARS;
        end else begin
            parse_st = PM_TEXT;
        end
    endfunction

    task automatic predict_byte(input logic [7:0] c);
        logic [7:0] ch [4];
        int n;
        char_word_t w;
        n = 0;
        case (parse_st)
            PM_ESC: begin
                parse_st = PM_TEXT;
                if (c == "[") parse_st = PM_SQUARE;
                else if (c == "]") parse_st = PM_NONSTD;
                else if (c == "%") parse_st = PM_PERCENT;
                else if (c == "(") parse_st = PM_SETG0;
                else if (c == ")") parse_st = PM_SETG1;
                else if (c == "#") parse_st = PM_HASH;
                else if (c == "E" || c == "D") begin
                    at_line_end = 1'b1;
                    ch[0] = LF;
                    n = 1;
                end
            end
            PM_NONSTD: begin
                if (c == "P") begin
                    sep_cnt  = 4'd0;
                    parse_st = PM_PALETTE;
                end else begin
                    parse_st = PM_TEXT;
                end
            end
            PM_PALETTE: begin
                if (is_hex(c)) begin
                    sep_cnt = sep_cnt + 4'd1;
                    if (sep_cnt >= 4'd7) parse_st = PM_TEXT;
                end else begin
                    parse_st = PM_TEXT;
                end
            end
            PM_SQUARE: begin
                sep_cnt = 4'd0;
                if (c == "[") parse_st = PM_FUNCKEY;
                else if (c == "?") parse_st = PM_GETPARS;
                else bracket_step(c);
            end
            PM_GETPARS: bracket_step(c);
            PM_GOTPARS, PM_FUNCKEY, PM_HASH, PM_SETG0, PM_SETG1, PM_PERCENT: begin
                parse_st = PM_TEXT;
            end
            default: begin
                parse_st = PM_TEXT;
                if (c == LF) begin
                    at_line_end = 1'b1;
                    ch[0] = LF;
                    n = 1;
                end else if (c == CR || c == SO || c == SI || c == CAN || c == SUB) begin
                    n = 0;
                end else if (c == ESC) begin
                    parse_st = PM_ESC;
                end else if (c == CSI) begin
                    parse_st = PM_SQUARE;
                end else begin
                    at_line_end = 1'b0;
                    if (c == TAB || (c >= 8'd32 && c <= 8'd126) || c >= 8'd160) begin
                        ch[0] = c;
                        n = 1;
                    end else if (c == DEL) begin
                        ch[0] = "^";
                        ch[1] = "?";
                        n = 2;
                    end else if (c >= 8'd128) begin
                        ch[0] = "\\";
                        ch[1] = "0" + c[7:6];
                        ch[2] = "0" + c[5:3];
                        ch[3] = "0" + c[2:0];
                        n = 4;
                    end else if (c == VT || c == FF) begin
                        ch[0] = "0";
                        ch[1] = "x";
                        ch[2] = (c == VT) ? "B" : "C";
                        n = 3;
                    end else begin
                        ch[0] = "^";
                        ch[1] = c + 8'd64;
                        n = 2;
                    end
                end
            end
        endcase
        for (int k = 0; k < n; k++) begin
            w.ch   = ch[k];
            w.last = (k == n - 1);
            w.nl   = at_line_end;
            exp_chars.push_back(w);
        end
    endtask

    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < send_idle) begin
            in_if.valid   <= 1'b0;
            in_if.in_byte <= 8'($urandom_range(255));
            @(posedge i_clk);
        end
        in_if.valid   <= 1'b1;
        in_if.in_byte <= b;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        predict_byte(b);
        n_in++;
    endtask

    function automatic logic [7:0] rand_hex();
        string hx;
        hx = "0123456789ABCDEFabcdef";
        return hx[$urandom_range(21)];
    endfunction

    task automatic send_csi();
        int seps;
        if ($urandom_range(1)) begin
            send_byte(ESC);
            send_byte("[");
        end else begin
            send_byte(CSI);
        end
        n_seq++;
        case ($urandom_range(5))
            0: send_byte("?");
            1: begin
                send_byte("[");
                send_byte(8'($urandom_range(255)));
                return;
            end
            default: ;
        endcase
        seps = ($urandom_range(3) == 0) ? $urandom_range(16, 14) : $urandom_range(3);
        for (int i = 0; i <= seps; i++) begin
            repeat ($urandom_range(2)) send_byte(8'("0" + $urandom_range(9)));
            if (i < seps) send_byte(";");
        end
        if ($urandom_range(1)) send_byte(8'("A" + $urandom_range(25)));
        else send_byte(8'($urandom_range(255)));
    endtask

    task automatic send_palette();
        int digits;
        send_byte(ESC);
        send_byte("]");
        send_byte("P");
        n_seq++;
        digits = $urandom_range(8);
        repeat (digits) send_byte(rand_hex());
        if (digits < 7 && $urandom_range(1)) send_byte(8'("G" + $urandom_range(19)));
    endtask

    task automatic send_esc_other();
        logic [7:0] sel [4];
        sel = '{"(", ")", "#", "%"};
        send_byte(ESC);
        n_seq++;
        case ($urandom_range(3))
            0: begin
                send_byte(sel[$urandom_range(3)]);
                send_byte(8'($urandom_range(255)));
            end
            1: begin
                send_byte("]");
                send_byte(8'($urandom_range(255)));
            end
            2: send_byte($urandom_range(1) ? "E" : "D");
            default: send_byte(8'($urandom_range(255)));
        endcase
    endtask

    task automatic test_plain_bytes();
        logic [7:0] pat [14];
        pat = '{8'h00, TAB, LF, VT, FF, CR, CAN, 8'h1F, 8'h7E, DEL, 8'h80, 8'h9F, 8'hA0,
                8'hFF};
        foreach (pat[i]) send_byte(pat[i]);
    endtask

    task automatic test_escape_forms();
        logic [7:0] pat [22];
        pat = '{ESC, "E", ESC, "[", "1", ";", "2", "m", CSI, "[", "A",
                ESC, "]", "P", "1", "a", "F", "0", "9", "c", "E", "X"};
        foreach (pat[i]) send_byte(pat[i]);
        n_seq += 4;
    endtask

    task automatic test_random_stream(input int n_items);
        int start;
        start = n_in;
        while (n_in - start < n_items) begin
            case ($urandom_range(9))
                0, 1, 2, 3: send_byte(8'($urandom_range(255)));
                4: send_byte($urandom_range(1) ? 8'($urandom_range(31))
                                               : 8'($urandom_range(159, 127)));
                5, 6: send_csi();
                7: send_palette();
                default: send_esc_other();
            endcase
        end
    endtask

    always @(posedge i_clk) begin
        out_if.ready <= ($urandom_range(99) >= recv_stall);
    end

    always @(posedge i_clk) begin : check_chars
        char_word_t w;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            n_out++;
            if (exp_chars.size() == 0) begin
                $display("%0t: unexpected char: expected none, got %h last %b nl %b", $time,
                         out_if.out_char, out_if.last_of_run, out_if.line_ended);
                errors++;
            end else begin
                w = exp_chars.pop_front();
                if (out_if.out_char !== w.ch) begin
                    $display("%0t: out_char expected %h, got %h", $time, w.ch,
                             out_if.out_char);
                    errors++;
                end
                if (out_if.last_of_run !== w.last) begin
                    $display("%0t: last_of_run expected %b, got %b", $time, w.last,
                             out_if.last_of_run);
                    errors++;
                end
                if (out_if.line_ended !== w.nl) begin
                    $display("%0t: line_ended expected %b, got %b", $time, w.nl,
                             out_if.line_ended);
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
                quiet_count = 0;
            else
                quiet_count++;
            if (quiet_count >= STALL_LIMIT) begin
                $display("%0t: no progress for %0d cycles, %0d chars outstanding", $time,
                         STALL_LIMIT, exp_chars.size());
                $display("tb failed");
                $finish;
            end
        end
    end

    initial begin
        i_rst_n       = 1'b0;
        in_if.valid   = 1'b0;
        in_if.in_byte = 8'h00;
        out_if.ready  = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_idle  = 0;
        recv_stall = 0;
        test_plain_bytes();
        test_escape_forms();
        test_random_stream(15);

        send_idle  = 69;
        recv_stall = 0;
        test_random_stream(15);

        send_idle  = 0;
        recv_stall = 69;
        test_random_stream(15);

        send_idle  = 31;
        recv_stall = 31;
        test_random_stream(15);

        in_if.valid <= 1'b0;
        while (exp_chars.size() != 0) @(posedge i_clk);
        repeat (LATENCY_WAIT) @(posedge i_clk);

        $display("run: %0d bytes in, %0d chars out, %0d escape sequences", n_in, n_out,
                 n_seq);
        $display("run: idling phases none, sender 69%%, receiver 69%%, both 31%%");
        if (errors == 0 && exp_chars.size() == 0) begin
            $display("tb passed");
        end else begin
            $display("tb failed");
        end
        $finish;
    end
endmodule
